[design/esc_ramp_pkg.sv]
// ----------------------------------------------------------------------------
// esc_ramp_pkg
// Types, register indexes and constants shared by the ESC arming ramp block.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_ramp_pkg;

    // Payload widths
    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 48;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_W       = 28;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NEUTRAL_PULSE = 3'd0,
        CFG_FORWARD_PULSE = 3'd1,
        CFG_REVERSE_PULSE = 3'd2,
        CFG_PWM_PERIOD    = 3'd3,
        CFG_DUTY_BITS     = 3'd4,
        CFG_BRAKE_HOLD    = 3'd5,
        CFG_ARM_HOLD      = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers
    localparam logic [11:0] RST_NEUTRAL_PULSE = 12'd1500;
    localparam logic [11:0] RST_FORWARD_PULSE = 12'd2000;
    localparam logic [11:0] RST_REVERSE_PULSE = 12'd1000;
    localparam logic [15:0] RST_PWM_PERIOD    = 16'd20000;
    localparam logic [4:0]  RST_DUTY_BITS     = 5'd16;
    localparam logic [15:0] RST_BRAKE_HOLD    = 16'd300;
    localparam logic [15:0] RST_ARM_HOLD      = 16'd300;

    // Speed handling, in half-percent units
    localparam logic signed [8:0] TARGET_LIMIT  = 9'sd200;
    localparam logic [7:0]        STEP_UP       = 8'd1;
    localparam logic [7:0]        STEP_DOWN     = 8'd4;
    localparam logic [4:0]        MAX_DUTY_BITS = 5'd16;

    // Map quotient by 100 on a 19-bit magnitude: multiply by ceil(2^26 / 100)
    // and keep bits 26 up, exact for every magnitude below 2^19.
    // Duty quotient on 28 bits through the restoring divider.
    localparam int                 MAP_MAG_W       = 19;
    localparam int                 MAP_RECIP_W     = 20;
    localparam logic [19:0]        MAP_RECIP       = 20'd671089;
    localparam int                 MAP_RECIP_SHIFT = 26;
    localparam int                 MAP_QUOT_W      = 13;
    localparam logic [4:0]         DUTY_DIV_STEPS  = 5'd28;

    typedef enum logic [2:0] {
        MODE_NEUTRAL = 3'd0,
        MODE_FORWARD = 3'd1,
        MODE_BRAKING = 3'd2,
        MODE_ARMING  = 3'd3,
        MODE_REVERSE = 3'd4
    } mode_t;

    // What the back end has to drive for one tick
    typedef enum logic [2:0] {
        DRV_NONE    = 3'd0,
        DRV_NEUTRAL = 3'd1,
        DRV_REVERSE = 3'd2,
        DRV_MAP_FWD = 3'd3,
        DRV_MAP_REV = 3'd4
    } drive_t;

    typedef enum logic [2:0] {
        BK_IDLE     = 3'd0,
        BK_MAP_MUL  = 3'd1,
        BK_MAP_ABS  = 3'd2,
        BK_MAP_DIV  = 3'd3,
        BK_CLAMP    = 3'd4,
        BK_DUTY_MUL = 3'd5,
        BK_DUTY_DIV = 3'd6,
        BK_DONE     = 3'd7
    } back_state_t;

    typedef struct packed {
        logic [11:0] neutral_pulse_us;
        logic [11:0] forward_pulse_us;
        logic [11:0] reverse_pulse_us;
        logic [15:0] pwm_period_us;
        logic [4:0]  duty_bits;
        logic [15:0] brake_hold_ms;
        logic [15:0] arm_hold_ms;
    } cfg_t;

    typedef struct packed {
        drive_t            kind;
        logic [6:0]        pct;
        mode_t             mode;
        logic signed [8:0] signed_speed;
    } cmd_t;

endpackage

`default_nettype wire

[design/esc_ramp_front.sv]
// ----------------------------------------------------------------------------
// esc_ramp_front
// Accepts ticks, holds the configuration, runs the mode machine and the speed
// ramp, and queues one drive command for every tick.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ramp_front
    import esc_ramp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                   q_full,
    output logic                        q_push,
    output cmd_t                        q_push_data,
    output cfg_t                        cfg
);

    cfg_t        cfg_reg;
    mode_t       mode_reg,  mode_next;
    logic [7:0]  speed_reg, speed_next;
    logic [31:0] entry_reg, entry_next;

    logic signed [8:0] tgt_raw;
    logic signed [8:0] tgt;
    logic signed [8:0] tgt_neg;
    logic [31:0]       now_ms;
    logic [31:0]       elapsed;
    logic [7:0]        speed_dec;
    drive_t            kind;
    logic [8:0]        speed_ext;

    function automatic logic [7:0] ramp(input logic [7:0] cur, input logic [7:0] goal);
        logic [8:0] lim;
        begin
            lim = {1'b0, goal} + {1'b0, STEP_DOWN};
            if (cur < goal)
                ramp = cur + STEP_UP;
            else if ({1'b0, cur} > lim)
                ramp = cur - STEP_DOWN;
            else
                ramp = goal;
        end
    endfunction

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && s_axis_tready;
    assign cfg           = cfg_reg;

    assign tgt_raw = $signed(s_axis_tdata[8:0]);
    assign now_ms  = s_axis_tdata[40:9];
    assign elapsed = now_ms - entry_reg;
    assign tgt_neg = -tgt;
    assign speed_dec = (speed_reg > STEP_DOWN) ? (speed_reg - STEP_DOWN) : 8'd0;

    always_comb
    begin
        if (tgt_raw > TARGET_LIMIT)
            tgt = TARGET_LIMIT;
        else if (tgt_raw < -TARGET_LIMIT)
            tgt = -TARGET_LIMIT;
        else
            tgt = tgt_raw;
    end

    always_comb
    begin
        mode_next  = mode_reg;
        speed_next = speed_reg;
        entry_next = entry_reg;
        kind       = DRV_NONE;
        case (mode_reg)
            MODE_FORWARD:
            begin
                if (tgt < 0) begin
                    speed_next = 8'd0;
                    mode_next  = MODE_BRAKING;
                    entry_next = now_ms;
                end else if (tgt == 0) begin
                    speed_next = speed_dec;
                    if (speed_dec == 8'd0) begin
                        kind       = DRV_NEUTRAL;
                        mode_next  = MODE_NEUTRAL;
                        entry_next = now_ms;
                    end else begin
                        kind = DRV_MAP_FWD;
                    end
                end else begin
                    speed_next = ramp(speed_reg, tgt[7:0]);
                    kind       = DRV_MAP_FWD;
                end
            end
            MODE_BRAKING:
            begin
                kind = DRV_REVERSE;
                if (elapsed >= {16'd0, cfg_reg.brake_hold_ms}) begin
                    mode_next  = MODE_ARMING;
                    entry_next = now_ms;
                end
            end
            MODE_ARMING:
            begin
                kind = DRV_NEUTRAL;
                if (elapsed >= {16'd0, cfg_reg.arm_hold_ms}) begin
                    entry_next = now_ms;
                    if (tgt < 0) begin
                        speed_next = 8'd0;
                        mode_next  = MODE_REVERSE;
                    end else begin
                        mode_next  = MODE_NEUTRAL;
                    end
                end
            end
            MODE_REVERSE:
            begin
                if (tgt >= 0) begin
                    speed_next = 8'd0;
                    kind       = DRV_NEUTRAL;
                    mode_next  = MODE_NEUTRAL;
                    entry_next = now_ms;
                end else begin
                    speed_next = ramp(speed_reg, tgt_neg[7:0]);
                    kind       = DRV_MAP_REV;
                end
            end
            default:
            begin
                // neutral, and any stray code treated as neutral
                kind      = DRV_NEUTRAL;
                mode_next = MODE_NEUTRAL;
                if (tgt > 0) begin
                    speed_next = 8'd0;
                    mode_next  = MODE_FORWARD;
                    entry_next = now_ms;
                end else if (tgt < 0) begin
                    speed_next = 8'd0;
                    mode_next  = MODE_BRAKING;
                    entry_next = now_ms;
                end
            end
        endcase
    end

    assign speed_ext = {1'b0, speed_next};

    always_comb
    begin
        q_push_data.kind = kind;
        q_push_data.pct  = speed_next[7:1];
        q_push_data.mode = mode_next;
        if (mode_next == MODE_REVERSE)
            q_push_data.signed_speed = -$signed(speed_ext);
        else
            q_push_data.signed_speed = $signed(speed_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_NEUTRAL;
            speed_reg <= 8'd0;
            entry_reg <= 32'd0;
        end else if (q_push) begin
            mode_reg  <= mode_next;
            speed_reg <= speed_next;
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.neutral_pulse_us <= RST_NEUTRAL_PULSE;
            cfg_reg.forward_pulse_us <= RST_FORWARD_PULSE;
            cfg_reg.reverse_pulse_us <= RST_REVERSE_PULSE;
            cfg_reg.pwm_period_us    <= RST_PWM_PERIOD;
            cfg_reg.duty_bits        <= RST_DUTY_BITS;
            cfg_reg.brake_hold_ms    <= RST_BRAKE_HOLD;
            cfg_reg.arm_hold_ms      <= RST_ARM_HOLD;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_NEUTRAL_PULSE: cfg_reg.neutral_pulse_us <= cfg_wdata[11:0];
                CFG_FORWARD_PULSE: cfg_reg.forward_pulse_us <= cfg_wdata[11:0];
                CFG_REVERSE_PULSE: cfg_reg.reverse_pulse_us <= cfg_wdata[11:0];
                CFG_PWM_PERIOD:    cfg_reg.pwm_period_us    <= cfg_wdata;
                CFG_DUTY_BITS:     cfg_reg.duty_bits        <= cfg_wdata[4:0];
                CFG_BRAKE_HOLD:    cfg_reg.brake_hold_ms    <= cfg_wdata;
                CFG_ARM_HOLD:      cfg_reg.arm_hold_ms      <= cfg_wdata;
                default:           ;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/esc_ramp_queue.sv]
// ----------------------------------------------------------------------------
// esc_ramp_queue
// Short command queue between the mode machine and the pulse/duty engine.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ramp_queue
    import esc_ramp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_data,
    output logic      not_empty
);

    cmd_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

[design/esc_ramp_back.sv]
// ----------------------------------------------------------------------------
// esc_ramp_back
// Turns a drive command into a clamped pulse and a PWM compare value: the map
// divides by 100 through a reciprocal multiply, the duty through a restoring
// divider, and the result beat is held for the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ramp_back
    import esc_ramp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cfg_t                   cfg,
    input  wire logic                   q_valid,
    input  wire cmd_t                   q_data,
    output logic                        q_pop,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata
);

    back_state_t state_reg, state_next;

    // control and held state
    logic        out_valid_reg,  out_valid_next;
    logic [11:0] held_pulse_reg, held_pulse_next;
    logic [15:0] held_duty_reg,  held_duty_next;

    // payload
    cmd_t              cmd_reg,       cmd_next;
    logic signed [19:0] prod_reg,     prod_next;
    logic              neg_reg,       neg_next;
    logic [DIV_W-1:0]  div_reg,       div_next;
    logic [15:0]       rem_reg,       rem_next;
    logic [15:0]       divisor_reg,   divisor_next;
    logic [4:0]        cnt_reg,       cnt_next;
    logic [11:0]       us_reg,        us_next;
    logic              out_upd_reg,   out_upd_next;
    mode_t             out_mode_reg,  out_mode_next;
    logic signed [8:0] out_speed_reg, out_speed_next;

    logic [11:0]        map_end;
    logic signed [12:0] map_diff;
    logic signed [20:0] map_prod;
    logic [19:0]        prod_mag;
    logic [MAP_MAG_W+MAP_RECIP_W-1:0] map_recip_prod;
    logic signed [13:0] quot_s;
    logic signed [13:0] quot_u;
    logic signed [13:0] raw_us;
    logic [11:0]        clamped_us;
    logic [4:0]         bits_eff;
    logic [16:0]        maxd_full;
    logic [15:0]        maxd;
    logic [15:0]        period_eff;
    logic [15:0]        duty_sat;
    logic [16:0]        trial;
    logic [16:0]        trial_sub;
    logic               trial_ge;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_speed_reg, out_mode_reg, out_upd_reg,
                            held_duty_reg, held_pulse_reg};

    // map: neutral + pct * (end - neutral) / 100, quotient toward zero
    assign map_end  = (cmd_reg.kind == DRV_MAP_REV) ? cfg.reverse_pulse_us
                                                    : cfg.forward_pulse_us;
    assign map_diff = $signed({1'b0, map_end}) - $signed({1'b0, cfg.neutral_pulse_us});
    assign map_prod = $signed({1'b0, cmd_reg.pct}) * map_diff;
    assign prod_mag = prod_reg[19] ? 20'(-prod_reg) : prod_reg;
    assign map_recip_prod = {MAP_RECIP_W'(0), div_reg[MAP_MAG_W-1:0]}
                          * {MAP_MAG_W'(0), MAP_RECIP};
    assign quot_u   = $signed({1'b0, div_reg[12:0]});
    assign quot_s   = neg_reg ? -quot_u : quot_u;

    always_comb
    begin
        case (cmd_reg.kind)
            DRV_NEUTRAL: raw_us = $signed({2'b00, cfg.neutral_pulse_us});
            DRV_REVERSE: raw_us = $signed({2'b00, cfg.reverse_pulse_us});
            default:     raw_us = $signed({2'b00, cfg.neutral_pulse_us}) + quot_s;
        endcase
    end

    // reverse is tested first; with crossed limits, values below reverse clamp to it, others to forward
    always_comb
    begin
        if (raw_us < $signed({2'b00, cfg.reverse_pulse_us}))
            clamped_us = cfg.reverse_pulse_us;
        else if (raw_us > $signed({2'b00, cfg.forward_pulse_us}))
            clamped_us = cfg.forward_pulse_us;
        else
            clamped_us = raw_us[11:0];
    end

    assign bits_eff   = (cfg.duty_bits > MAX_DUTY_BITS) ? MAX_DUTY_BITS : cfg.duty_bits;
    assign maxd_full  = (17'd1 << bits_eff) - 17'd1;
    assign maxd       = maxd_full[15:0];
    assign period_eff = (cfg.pwm_period_us == 16'd0) ? 16'd1 : cfg.pwm_period_us;
    assign duty_sat   = (div_reg > {12'd0, maxd}) ? maxd : div_reg[15:0];

    // one restoring step per cycle
    assign trial     = {rem_reg, div_reg[DIV_W-1]};
    assign trial_ge  = (trial >= {1'b0, divisor_reg});
    assign trial_sub = trial - {1'b0, divisor_reg};

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        held_pulse_next = held_pulse_reg;
        held_duty_next  = held_duty_reg;
        cmd_next        = cmd_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        div_next        = div_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        cnt_next        = cnt_reg;
        us_next         = us_reg;
        out_upd_next    = out_upd_reg;
        out_mode_next   = out_mode_reg;
        out_speed_next  = out_speed_reg;
        q_pop           = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    case (q_data.kind)
                        DRV_NEUTRAL, DRV_REVERSE: state_next = BK_CLAMP;
                        DRV_MAP_FWD, DRV_MAP_REV: state_next = BK_MAP_MUL;
                        default:                  state_next = BK_DONE;
                    endcase
                end
            end
            BK_MAP_MUL:
            begin
                prod_next  = map_prod[19:0];
                state_next = BK_MAP_ABS;
            end
            BK_MAP_ABS:
            begin
                neg_next   = prod_reg[19];
                div_next   = {(DIV_W - MAP_MAG_W)'(0), prod_mag[MAP_MAG_W-1:0]};
                state_next = BK_MAP_DIV;
            end
            BK_MAP_DIV:
            begin
                // divide the magnitude by 100 with the scaled reciprocal
                div_next   = {(DIV_W - MAP_QUOT_W)'(0),
                              map_recip_prod[MAP_RECIP_SHIFT +: MAP_QUOT_W]};
                state_next = BK_CLAMP;
            end
            BK_DUTY_DIV:
            begin
                rem_next = trial_ge ? trial_sub[15:0] : trial[15:0];
                div_next = {div_reg[DIV_W-2:0], trial_ge};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                    state_next = BK_DONE;
            end
            BK_CLAMP:
            begin
                us_next    = clamped_us;
                state_next = BK_DUTY_MUL;
            end
            BK_DUTY_MUL:
            begin
                div_next     = {16'd0, us_reg} * {12'd0, maxd};
                rem_next     = 16'd0;
                divisor_next = period_eff;
                cnt_next     = DUTY_DIV_STEPS;
                state_next   = BK_DUTY_DIV;
            end
            BK_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    if (cmd_reg.kind != DRV_NONE)
                    begin
                        held_pulse_next = us_reg;
                        held_duty_next  = duty_sat;
                    end
                    out_upd_next   = (cmd_reg.kind != DRV_NONE);
                    out_mode_next  = cmd_reg.mode;
                    out_speed_next = cmd_reg.signed_speed;
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            out_valid_reg  <= 1'b0;
            held_pulse_reg <= 12'd0;
            held_duty_reg  <= 16'd0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            held_pulse_reg <= held_pulse_next;
            held_duty_reg  <= held_duty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        cnt_reg       <= cnt_next;
        us_reg        <= us_next;
        out_upd_reg   <= out_upd_next;
        out_mode_reg  <= out_mode_next;
        out_speed_reg <= out_speed_next;
    end

endmodule

`default_nettype wire

[design/esc_reverse_arming_ramp_core.sv]
// ----------------------------------------------------------------------------
// esc_reverse_arming_ramp_core
// ESC driver with brake-then-arm reverse, ramped speed, pulse map and PWM duty.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | contents
//  s_axis   | in        | tvalid/tready            | one tick: target, time stamp
//  m_axis   | out       | tvalid/tready            | one result beat per tick
//  cfg      | in        | cfg_we, no back-pressure | register index and value
//
//  The result beat is registered. A tick that drives nothing skips every
//  arithmetic step; a fixed neutral or reverse pulse passes the clamp, the
//  duty multiply and the 28-step duty division, and a mapped pulse adds a
//  multiply, a magnitude step and a reciprocal multiply before the clamp.
//  The mode machine takes a tick in its accept cycle; a two-entry command
//  queue and the output register let either side stall alone.
//  Reset restores the register defaults, neutral mode and zero held pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_reverse_arming_ramp_core
    import esc_ramp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // [8:0] target_half_pct, [40:9] now_ms, [47:41] zero
    input  wire logic [TDATA_IN_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [11:0] pulse_width_us, [27:12] duty_value, [28] pulse_updated,
    // [31:29] mode_code, [40:32] signed_speed_half_pct, [47:41] zero
    output logic [TDATA_OUT_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg;
    cmd_t push_data;
    cmd_t pop_data;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_not_empty;

    esc_ramp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (push_data),
        .cfg           (cfg)
    );

    esc_ramp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty)
    );

    esc_ramp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_not_empty),
        .q_data        (pop_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[design/esc_ramp_chk.sv]
// ----------------------------------------------------------------------------
// esc_ramp_chk
// Port-level checks on the result stream of the ESC arming ramp block.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ramp_chk
    import esc_ramp_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [TDATA_OUT_W-1:0] m_axis_tdata
);

    logic              upd;
    logic [2:0]        mode_bits;
    logic signed [8:0] speed;

    assign upd       = m_axis_tdata[28];
    assign mode_bits = m_axis_tdata[31:29];
    assign speed     = $signed(m_axis_tdata[40:32]);

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    a_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> mode_bits <= MODE_REVERSE)
        else $error("mode code out of range");

    // speed sign follows the mode; idle modes carry no speed
    a_speed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (mode_bits == MODE_FORWARD && speed >= 0 && speed <= TARGET_LIMIT) ||
            (mode_bits == MODE_REVERSE && speed <= 0 && speed >= -TARGET_LIMIT) ||
            (mode_bits != MODE_FORWARD && mode_bits != MODE_REVERSE && speed == 0))
        else $error("speed does not match mode");

    // only the step from forward into braking skips the pulse write
    a_skip: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !upd |-> mode_bits == MODE_BRAKING)
        else $error("pulse write skipped outside braking entry");

endmodule

bind esc_reverse_arming_ramp_core esc_ramp_chk u_esc_ramp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
